[hw/rtl/qbph_pkg.sv]
// Shared constants for the quartic Bezier patch height evaluator.
package qbph_pkg;

  localparam int HEIGHT_BITS_DEF     = 24;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int GRID_SIDE           = 5;
  localparam int GRID_POINTS         = 25;
  localparam int MID_DEPTH           = 4;
  localparam int OUT_DEPTH           = 8;
  localparam int IDX_BITS            = 5;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

[hw/rtl/qbph_fifo.sv]
// Small synchronous queue with a live count.
module qbph_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);
  localparam int PB = $clog2(DEPTH);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [PB-1:0]     wr_ptr_r, rd_ptr_r;
  logic [PB:0]       count_r;
  logic              do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign rdata  = mem[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PB+1)'(push) - (PB+1)'(do_pop);
    end
  end
endmodule

[hw/rtl/qbph_front.sv]
// Front end: saturates u and v and forms the Bernstein weights in two stages.
module qbph_front import qbph_pkg::*; #(
  parameter int HB = HEIGHT_BITS_DEF,
  parameter int FB = PARAM_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_mode,
  input  logic [IDX_BITS-1:0]                in_index,
  input  logic [HB-1:0]                      in_height,
  input  logic [FB:0]                        in_u,
  input  logic [FB:0]                        in_v,
  output logic                               out_valid,
  output logic [1+IDX_BITS+HB+10*(FB+1)-1:0] out_data,
  output logic [1:0]                         inflight
);
  localparam int WB = FB + 1;
  localparam int PW = 2*FB + 4;
  localparam logic [WB-1:0] ONE  = WB'(1) << FB;
  localparam logic [PW-1:0] HALF = PW'(1) << (FB-1);

  function automatic logic [WB-1:0] rnd(input logic [PW-1:0] x);
    return WB'((x + HALF) >> FB);
  endfunction

  logic [WB-1:0] coord [2];
  logic [WB-1:0] a [2];
  logic [WB-1:0] b [2];
  logic [WB-1:0] aa_nxt [2], bb_nxt [2], ab_nxt [2];
  logic [WB-1:0] aa_r [2], bb_r [2], ab_r [2];
  logic [PW-1:0] abab [2];
  logic [WB-1:0] w_nxt [2][GRID_SIDE];
  logic [WB-1:0] w_r [2][GRID_SIDE];

  logic                v1_r, v2_r;
  logic                mode1_r, mode2_r;
  logic [IDX_BITS-1:0] idx1_r, idx2_r;
  logic [HB-1:0]       h1_r, h2_r;

  assign coord[0] = in_u;
  assign coord[1] = in_v;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      a[k] = (coord[k] > ONE) ? ONE : coord[k];
      b[k] = ONE - a[k];
      aa_nxt[k] = rnd(PW'(a[k]) * PW'(a[k]));
      bb_nxt[k] = rnd(PW'(b[k]) * PW'(b[k]));
      ab_nxt[k] = rnd(PW'(a[k]) * PW'(b[k]));
      abab[k]   = PW'(ab_r[k]) * PW'(ab_r[k]);
      w_nxt[k][0] = rnd(PW'(bb_r[k]) * PW'(bb_r[k]));
      w_nxt[k][1] = rnd((PW'(ab_r[k]) * PW'(bb_r[k])) << 2);
      w_nxt[k][2] = rnd((abab[k] << 2) + (abab[k] << 1));
      w_nxt[k][3] = rnd((PW'(aa_r[k]) * PW'(ab_r[k])) << 2);
      w_nxt[k][4] = rnd(PW'(aa_r[k]) * PW'(aa_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    aa_r    <= aa_nxt;
    bb_r    <= bb_nxt;
    ab_r    <= ab_nxt;
    w_r     <= w_nxt;
    mode1_r <= in_mode;
    idx1_r  <= in_index;
    h1_r    <= in_height;
    mode2_r <= mode1_r;
    idx2_r  <= idx1_r;
    h2_r    <= h1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    for (int k = 0; k < GRID_SIDE; k++) begin
      out_data[k*WB +: WB]             = w_r[1][k];
      out_data[(GRID_SIDE+k)*WB +: WB] = w_r[0][k];
    end
    out_data[10*WB +: HB]             = h2_r;
    out_data[10*WB+HB +: IDX_BITS]    = idx2_r;
    out_data[10*WB+HB+IDX_BITS]       = mode2_r;
  end

  assign out_valid = v2_r;
  assign inflight  = 2'(v1_r) + 2'(v2_r);
endmodule

[hw/rtl/qbph_back.sv]
// Back end: control height store and the pipelined 25-term weighted sum.
module qbph_back import qbph_pkg::*; #(
  parameter int HB = HEIGHT_BITS_DEF,
  parameter int FB = PARAM_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               mid_empty,
  input  logic [1+IDX_BITS+HB+10*(FB+1)-1:0] mid_data,
  output logic                               mid_pop,
  input  logic [$clog2(OUT_DEPTH):0]         out_count,
  output logic                               res_push,
  output logic [HB-1:0]                      res_height
);
  localparam int WB   = FB + 1;
  localparam int PRW  = HB + FB + 2;
  localparam int SW   = PRW + 3;
  localparam int RW   = HB + 2;
  localparam int TPW  = RW + WB + 1;
  localparam int TSW  = TPW + 3;
  localparam int OCW  = $clog2(OUT_DEPTH) + 1;
  localparam logic [SW-1:0]  HALF_S = SW'(1) << (FB-1);
  localparam logic [TSW-1:0] HALF_T = TSW'(1) << (FB-1);
  localparam logic signed [TSW-1:0] HMAX = TSW'((64'sd1 <<< (HB-1)) - 1);
  localparam logic signed [TSW-1:0] HMIN = -HMAX - TSW'(1);

  logic                  mode;
  logic [IDX_BITS-1:0]   idx;
  logic [HB-1:0]         hin;
  logic [WB-1:0]         wu [GRID_SIDE];
  logic [WB-1:0]         wv [GRID_SIDE];

  logic signed [HB-1:0]  heights_r [GRID_POINTS];
  logic signed [PRW-1:0] prod_nxt [GRID_POINTS];
  logic signed [PRW-1:0] prod_r [GRID_POINTS];
  logic [WB-1:0]         wv1_r [GRID_SIDE];
  logic [WB-1:0]         wv2_r [GRID_SIDE];
  logic signed [SW-1:0]  rsum [GRID_SIDE];
  logic signed [RW-1:0]  row_nxt [GRID_SIDE];
  logic signed [RW-1:0]  row_r [GRID_SIDE];
  logic signed [TPW-1:0] tprod_nxt [GRID_SIDE];
  logic signed [TPW-1:0] tprod_r [GRID_SIDE];
  logic signed [TSW-1:0] tsum, tot;
  logic [HB-1:0]         res_nxt, res_r;
  logic                  q1_r, q2_r, q3_r, q4_r;
  logic [OCW:0]          pending;

  always_comb begin
    for (int k = 0; k < GRID_SIDE; k++) begin
      wv[k] = mid_data[k*WB +: WB];
      wu[k] = mid_data[(GRID_SIDE+k)*WB +: WB];
    end
    hin  = mid_data[10*WB +: HB];
    idx  = mid_data[10*WB+HB +: IDX_BITS];
    mode = mid_data[10*WB+HB+IDX_BITS];
  end

  // Pop only when the result queue has room for everything still in flight.
  assign pending = (OCW+1)'(out_count) + (OCW+1)'(q1_r) + (OCW+1)'(q2_r)
                 + (OCW+1)'(q3_r) + (OCW+1)'(q4_r);
  assign mid_pop = !mid_empty && (pending < (OCW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (mid_pop && (mode == MODE_LOAD) && (idx < IDX_BITS'(GRID_POINTS))) begin
      heights_r[idx] <= hin;
    end
  end

  always_comb begin
    for (int i = 0; i < GRID_SIDE; i++) begin
      for (int j = 0; j < GRID_SIDE; j++) begin
        prod_nxt[i*GRID_SIDE+j] = PRW'(heights_r[i*GRID_SIDE+j] * $signed({1'b0, wu[j]}));
      end
    end
    for (int i = 0; i < GRID_SIDE; i++) begin
      rsum[i] = '0;
      for (int j = 0; j < GRID_SIDE; j++) begin
        rsum[i] = rsum[i] + SW'(prod_r[i*GRID_SIDE+j]);
      end
      row_nxt[i]   = RW'((rsum[i] + $signed(HALF_S)) >>> FB);
      tprod_nxt[i] = TPW'(row_r[i] * $signed({1'b0, wv2_r[i]}));
    end
    tsum = '0;
    for (int i = 0; i < GRID_SIDE; i++) begin
      tsum = tsum + TSW'(tprod_r[i]);
    end
    tot = (tsum + $signed(HALF_T)) >>> FB;
    if (tot > HMAX) res_nxt = HB'(HMAX);
    else if (tot < HMIN) res_nxt = HB'(HMIN);
    else res_nxt = HB'(tot);
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    wv1_r   <= wv;
    wv2_r   <= wv1_r;
    row_r   <= row_nxt;
    tprod_r <= tprod_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r <= 1'b0;
      q2_r <= 1'b0;
      q3_r <= 1'b0;
      q4_r <= 1'b0;
    end else begin
      q1_r <= mid_pop && (mode == MODE_QUERY);
      q2_r <= q1_r;
      q3_r <= q2_r;
      q4_r <= q3_r;
    end
  end

  assign res_push   = q4_r;
  assign res_height = res_r;
endmodule

[hw/rtl/quartic_bezier_patch_height.sv]
// A query's result passes the weight front, the middle queue, the evaluator and the result queue before it is visible.
// Throughput: one item per cycle, loads and queries alike; the two-stage weight
// front, a 4-entry middle queue and the 4-stage evaluator with an 8-entry result
// queue keep the rate when neither side stalls.
// Reset: synchronous active-low rst_n clears all queues and valid flags;
// control heights are undefined until loaded.
module quartic_bezier_patch_height import qbph_pkg::*; #(
  parameter int HEIGHT_BITS     = HEIGHT_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_mode,
  input  logic [IDX_BITS-1:0]           in_point_index,
  input  logic signed [HEIGHT_BITS-1:0] in_point_height,
  input  logic [PARAM_FRAC_BITS:0]      in_u_coord,
  input  logic [PARAM_FRAC_BITS:0]      in_v_coord,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [HEIGHT_BITS-1:0] out_surface_height
);
  localparam int MW  = 1 + IDX_BITS + HEIGHT_BITS + 10*(PARAM_FRAC_BITS+1);
  localparam int MCW = $clog2(MID_DEPTH) + 1;
  localparam int OCW = $clog2(OUT_DEPTH) + 1;

  logic                   in_xfer;
  logic                   mid_push, mid_pop, mid_empty;
  logic [MW-1:0]          mid_wdata, mid_rdata;
  logic [MCW-1:0]         mid_count;
  logic [1:0]             front_inflight;
  logic                   res_push;
  logic [HEIGHT_BITS-1:0] res_height, out_data;
  logic [OCW-1:0]         out_count;

  // Hold off input while the middle queue could not absorb the front's contents.
  assign in_full = ((MCW+2)'(mid_count) + (MCW+2)'(front_inflight)) >= (MCW+2)'(MID_DEPTH);
  assign in_xfer = in_push && !in_full;

  qbph_front #(.HB(HEIGHT_BITS), .FB(PARAM_FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_xfer), .in_mode(in_mode), .in_index(in_point_index),
    .in_height(in_point_height), .in_u(in_u_coord), .in_v(in_v_coord),
    .out_valid(mid_push), .out_data(mid_wdata), .inflight(front_inflight)
  );

  qbph_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(mid_push), .wdata(mid_wdata), .pop(mid_pop),
    .rdata(mid_rdata), .empty(mid_empty), .count(mid_count)
  );

  qbph_back #(.HB(HEIGHT_BITS), .FB(PARAM_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .mid_empty(mid_empty), .mid_data(mid_rdata), .mid_pop(mid_pop),
    .out_count(out_count), .res_push(res_push), .res_height(res_height)
  );

  qbph_fifo #(.WIDTH(HEIGHT_BITS), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_push), .wdata(res_height), .pop(out_pop),
    .rdata(out_data), .empty(out_empty), .count(out_count)
  );

  assign out_surface_height = out_data;

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> (mid_count < MCW'(MID_DEPTH)))
    else $error("middle queue overflow");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (out_count < OCW'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_front_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (front_inflight != 2'd0))
    else $error("accepted item lost in front end");
endmodule
